// ----- design/dgsp_pkg.sv -----
package dgsp_pkg;
   localparam int MaxVertices = 32;
   localparam int VtxWidth = $clog2(MaxVertices);
   localparam int AddrWidth = 2 * VtxWidth;
   localparam int WeightWidth = 15;
   localparam int DistWidth = 20;
   localparam int CountWidth = 6;
   localparam logic [DistWidth-1:0] Unreachable = 20'd999999;
   localparam logic [WeightWidth-1:0] WeightLimit = 15'd30000;

   localparam logic [1:0] ModeClear = 2'd0;
   localparam logic [1:0] ModeEdge = 2'd1;
   localparam logic [1:0] ModeQuery = 2'd2;

   localparam logic [1:0] RegVertexCount = 2'd0;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_EDGE2, ST_INIT, ST_SCAN, ST_SCAN_END,
      ST_RELAX_RD, ST_RELAX, ST_RESULT
   } state_type;

   typedef struct packed {
      logic clear;     // matrix write stores zero
      logic init;      // reset dist/mark entry at idx
      logic scan;      // compare entry idx against best
      logic scan_start;
      logic settle;    // mark pick, latch its distance
      logic relax;     // relax entry idx using matrix word read
      logic rd_row;    // issue matrix read pick,idx
      logic [VtxWidth-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic found;
      logic [DistWidth-1:0] target_dist;
   } dp_stat_type;
endpackage

// ----- design/dgsp_ctrl.sv -----
module dgsp_ctrl
   import dgsp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [1:0] mode,
   input  logic [CountWidth-1:0] vertex_a,
   input  logic [CountWidth-1:0] vertex_b,
   input  logic [CountWidth-1:0] vcount,
   input  dp_stat_type stat,
   output logic busy,
   output dp_cmd_type cmd,
   output logic mem_we,
   output logic [AddrWidth-1:0] mem_addr,
   output logic done
);
   state_type state_ff, state_in;
   logic [VtxWidth-1:0] idx_ff, idx_in, last_ff, last_in;
   logic [VtxWidth-1:0] a_ff, a_in, b_ff, b_in;
   logic [CountWidth-1:0] round_ff, round_in;
   logic bad_ff, bad_in;
   logic [CountWidth-1:0] n_eff;
   logic a_ok, b_ok;

   assign n_eff = (vcount == '0) ? CountWidth'(1) :
                  (vcount > CountWidth'(MaxVertices)) ? CountWidth'(MaxVertices) : vcount;
   assign a_ok = vertex_a != '0 && vertex_a <= CountWidth'(MaxVertices);
   assign b_ok = vertex_b != '0 && vertex_b <= CountWidth'(MaxVertices);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff <= '0;
         a_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         a_ff <= a_in;
      end
      last_ff <= last_in;
      b_ff <= b_in;
      round_ff <= round_in;
      bad_ff <= bad_in;
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      last_in = last_ff;
      a_in = a_ff;
      b_in = b_ff;
      round_in = round_ff;
      bad_in = bad_ff;
      cmd = '0;
      cmd.idx = idx_ff;
      mem_we = 1'b0;
      mem_addr = {a_ff, b_ff};
      done = 1'b0;
      busy = state_ff != ST_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            a_in = VtxWidth'(vertex_a - 1'b1);
            b_in = VtxWidth'(vertex_b - 1'b1);
            idx_in = '0;
            last_in = VtxWidth'(n_eff - 1'b1);
            round_in = CountWidth'(1);
            bad_in = vertex_a == '0 || vertex_a > n_eff || vertex_b == '0 || vertex_b > n_eff;
            if (start) begin
               unique case (mode)
                  ModeClear: begin
                     a_in = '0;
                     state_in = ST_CLEAR;
                  end
                  ModeEdge: if (a_ok && b_ok) state_in = ST_EDGE2;
                  ModeQuery: state_in = ST_INIT;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            mem_we = 1'b1;
            mem_addr = {a_ff, idx_ff};
            {a_in, idx_in} = {a_ff, idx_ff} + 1'b1;
            if (&{a_ff, idx_ff}) state_in = ST_IDLE;
         end
         ST_EDGE2: begin
            mem_we = 1'b1;
            mem_addr = {a_ff, b_ff};
            a_in = b_ff;
            b_in = a_ff;
            if (idx_ff[0] || a_ff == b_ff) begin
               state_in = ST_IDLE;
               idx_in = '0;
            end else idx_in = VtxWidth'(1);
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == last_ff) begin
               idx_in = '0;
               state_in = (bad_ff || round_ff >= n_eff) ? ST_RESULT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            cmd.scan_start = idx_ff == '0;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == last_ff) begin
               idx_in = '0;
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            if (stat.found) begin
               cmd.settle = 1'b1;
               state_in = ST_RELAX_RD;
            end else begin
               round_in = round_ff + 1'b1;
               state_in = (round_ff + 1'b1 >= n_eff) ? ST_RESULT : ST_SCAN;
            end
         end
         ST_RELAX_RD: begin
            cmd.rd_row = 1'b1;
            idx_in = idx_ff + 1'b1;
            state_in = ST_RELAX;
         end
         ST_RELAX: begin
            cmd.relax = 1'b1;
            cmd.rd_row = 1'b1;
            cmd.idx = VtxWidth'(idx_ff - 1'b1);
            idx_in = idx_ff + 1'b1;
            if (VtxWidth'(idx_ff - 1'b1) == last_ff) begin
               idx_in = '0;
               round_in = round_ff + 1'b1;
               state_in = (round_ff + 1'b1 >= n_eff) ? ST_RESULT : ST_SCAN;
            end
         end
         ST_RESULT: begin
            done = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_RELAX_RD || state_ff == ST_RELAX) mem_addr = '0;
   end
endmodule

// ----- design/dgsp_dpath.sv -----
module dgsp_dpath
   import dgsp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  dp_cmd_type cmd,
   input  logic mem_we,
   input  logic [AddrWidth-1:0] mem_addr,
   input  logic [WeightWidth-1:0] weight,
   input  logic [VtxWidth-1:0] src,
   input  logic [VtxWidth-1:0] dst,
   output dp_stat_type stat
);
   logic [WeightWidth-1:0] mat [MaxVertices*MaxVertices];
   logic [WeightWidth-1:0] rd_ff;
   logic [DistWidth-1:0] dist_ff [MaxVertices];
   logic [MaxVertices-1:0] mark_ff;
   logic [DistWidth-1:0] best_ff, best_in, pick_dist_ff;
   logic [VtxWidth-1:0] pick_ff, pick_in;
   logic found_ff, found_in;
   logic [WeightWidth-1:0] wsat;
   logic [DistWidth-1:0] cand;
   logic [AddrWidth-1:0] rd_addr;

   assign wsat = (weight > WeightLimit) ? WeightLimit : weight;
   assign rd_addr = cmd.rd_row ? {pick_ff, cmd.idx + VtxWidth'(cmd.relax)} : mem_addr;
   assign cand = pick_dist_ff + DistWidth'(rd_ff);

   always_ff @(posedge clock) begin
      if (mem_we) mat[mem_addr] <= (reset || cmd.clear) ? '0 : wsat;
      rd_ff <= mat[rd_addr];
   end

   always_comb begin
      best_in = cmd.scan_start ? Unreachable : best_ff;
      pick_in = pick_ff;
      found_in = cmd.scan_start ? 1'b0 : found_ff;
      if (cmd.scan && !mark_ff[cmd.idx] && dist_ff[cmd.idx] < best_in) begin
         best_in = dist_ff[cmd.idx];
         pick_in = cmd.idx;
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         best_ff <= best_in;
         pick_ff <= pick_in;
         found_ff <= found_in;
      end
      if (cmd.init) begin
         dist_ff[cmd.idx] <= (cmd.idx == src) ? '0 : Unreachable;
         mark_ff[cmd.idx] <= 1'b0;
      end
      if (cmd.settle) begin
         mark_ff[pick_ff] <= 1'b1;
         pick_dist_ff <= dist_ff[pick_ff];
      end
      if (cmd.relax && rd_ff != '0 && !mark_ff[cmd.idx] && cand < dist_ff[cmd.idx])
         dist_ff[cmd.idx] <= cand;
   end

   assign stat.found = found_ff;
   assign stat.target_dist = dist_ff[dst];
endmodule

// ----- design/dense_graph_shortest_path.sv -----
// A query's run time grows with the n vertices in use and is set by the scan and relax
// passes over the weight memory (one write port, one read port), one vertex a cycle.
// One item at a time; busy is high while an item is in flight.
// Reset: synchronous; a clearing pass over all 1024 matrix entries follows, busy high.
// Result beat: rsp_valid for one cycle; the receiver cannot stall.
module dense_graph_shortest_path
   import dgsp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_mode,
   input  logic [CountWidth-1:0] req_vertex_a,
   input  logic [CountWidth-1:0] req_vertex_b,
   input  logic [WeightWidth-1:0] req_weight,
   output logic rsp_valid,
   output logic [DistWidth-1:0] rsp_distance,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [CountWidth-1:0] vcount_ff;
   logic [WeightWidth-1:0] weight_ff;
   logic [VtxWidth-1:0] src_ff, dst_ff;
   dp_cmd_type cmd;
   dp_stat_type stat;
   logic mem_we, done;
   logic [AddrWidth-1:0] mem_addr;
   logic [DistWidth-1:0] dist_ff;
   logic valid_ff;
   logic bad_q_ff;
   logic [CountWidth-1:0] vcount_eff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == RegVertexCount) ?
                       {{(32-CountWidth){1'b0}}, vcount_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) vcount_ff <= CountWidth'(32);
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == RegVertexCount)
         vcount_ff <= csr_pwdata[CountWidth-1:0];
      if (start && !busy) begin
         weight_ff <= req_weight;
         src_ff <= VtxWidth'(req_vertex_a - 1'b1);
         dst_ff <= VtxWidth'(req_vertex_b - 1'b1);
      end
      valid_ff <= reset ? 1'b0 : done;
      if (done) dist_ff <= stat.target_dist;
   end

   // bad query (a vertex zero or above the count): ctrl goes from init to result; distance forced below
   assign vcount_eff = (vcount_ff == '0) ? CountWidth'(1) :
                       (vcount_ff > CountWidth'(MaxVertices)) ?
                       CountWidth'(MaxVertices) : vcount_ff;

   always_ff @(posedge clock) begin
      if (start && !busy)
         bad_q_ff <= req_vertex_a == '0 || req_vertex_b == '0 ||
                     req_vertex_a > vcount_eff || req_vertex_b > vcount_eff;
   end

   assign rsp_valid = valid_ff;
   assign rsp_distance = bad_q_ff ? Unreachable : dist_ff;

   dgsp_ctrl u_ctrl (
      .clock, .reset, .start, .mode(req_mode), .vertex_a(req_vertex_a),
      .vertex_b(req_vertex_b), .vcount(vcount_ff), .stat, .busy, .cmd,
      .mem_we, .mem_addr, .done
   );

   dgsp_dpath u_dpath (
      .clock, .reset, .cmd, .mem_we, .mem_addr, .weight(weight_ff),
      .src(src_ff), .dst(dst_ff), .stat
   );
endmodule
